// ----- src/pipe_pool_ring_fifo_assert.svh -----
// Assertion macros for the ring FIFO pool.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PIPE_POOL_RING_FIFO_ASSERT_SVH
`define PIPE_POOL_RING_FIFO_ASSERT_SVH

// Same-cycle implication.
`define PPRF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PPRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pprf_pkg.sv -----
// Shared types and constants for the ring FIFO pool.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pprf_pkg;

  localparam int FIFO_DEPTH  = 8;
  localparam int CHANNELS    = 4;
  localparam int MAX_RESULTS = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int BYTE_W = 8;
  localparam int CHAN_W = 2;
  localparam int MC_W   = 4;
  localparam int FILL_W = 4;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int AW    = (CHANNELS * FIFO_DEPTH > 1) ? $clog2(CHANNELS * FIFO_DEPTH) : 1;
  localparam int CMP_W = (CNT_W > MC_W) ? CNT_W : MC_W;
  localparam int QP_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_WRITE   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_FREE  = 3'd1,
    ST_INACTIVE = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    op_t               operation;
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] write_byte;
    logic [MC_W-1:0]   max_count;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [CHAN_W-1:0] channel_out;
    logic [BYTE_W-1:0] read_byte;
    logic [FILL_W-1:0] fill_level;
    logic              last;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [CHAN_W-1:0] chan;
    logic [CH_W-1:0]   ch;
    logic              ch_ok;
    logic [BYTE_W-1:0] wbyte;
    logic [MC_W-1:0]   max_count;
  } cmd_t;

  typedef struct packed {
    logic            reading;
    logic [MC_W-1:0] remaining;
  } bk_status_t;

endpackage

// ----- src/pipe_pool_ring_fifo.sv -----
// Top level of the ring FIFO pool: front end, command queue, back end.
// Depends on pprf_pkg, pprf_front, pprf_queue, pprf_back and the assert header.
`timescale 1ns / 1ps
`include "pipe_pool_ring_fifo_assert.svh"

// Pool of byte ring FIFOs. One input transaction on in_* carries a command:
// create, destroy, write one byte, or read up to max_count bytes. Results
// leave on out_*; every command yields one result, except a read that finds
// data, which yields one result per byte taken, the final one marked last.
// A command passes through the command queue and, once the back end is
// free, into the result register; a read instead yields its first byte
// after a registered read of the byte store. Create, destroy and write
// leave the back end free for the next command; a read holds it until its
// last byte is produced. A two-entry command queue lets the input keep
// taking commands while the back end is busy.
// Reset (rst_n low, synchronous) frees all channels and clears pointers
// and counts; stored bytes are not cleared.
// When the receiver asserts out_stall while a result is valid, the result register holds its
// transaction, the back end waits, and in_stall rises once the queue fills.

module pipe_pool_ring_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pprf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pprf_pkg::out_item_t out_data
);
  import pprf_pkg::*;

  logic       q_full, q_push, q_pop, q_valid;
  cmd_t       push_cmd, q_cmd;
  bk_status_t bk_stat;

  pprf_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  pprf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  pprf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .bk_stat   (bk_stat)
  );

  `PPRF_ASSERT_IMPL(a_err_is_last, out_valid && out_data.status != ST_OK, out_data.last, "error result not marked last")
  `PPRF_ASSERT_NEXT(a_run_gapless, out_valid && !out_stall && !out_data.last, out_valid, "gap inside a read run")
  `PPRF_ASSERT_NEXT(a_read_fills, bk_stat.reading && !out_valid, out_valid, "read sequencer left output empty")
  `PPRF_ASSERT_IMPL(a_read_rem, bk_stat.reading, bk_stat.remaining != '0, "read sequencer with no bytes left")

endmodule

// ----- src/pprf_front.sv -----
// Front end: accepts input transactions, checks the channel and clamps the
// read count, and pushes a command into the queue. Depends on pprf_pkg.
`timescale 1ns / 1ps

module pprf_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  pprf_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output pprf_pkg::cmd_t     q_cmd
);
  import pprf_pkg::*;

  logic [MC_W-1:0] mc;

  always_comb begin
    mc = in_data.max_count;
    if (mc == '0) begin
      mc = MC_W'(1);
    end else if (32'(in_data.max_count) > MAX_RESULTS) begin
      mc = MC_W'(MAX_RESULTS);
    end
  end

  always_comb begin
    q_cmd.op        = in_data.operation;
    q_cmd.chan      = in_data.channel;
    q_cmd.ch        = CH_W'(in_data.channel);
    q_cmd.ch_ok     = 32'(in_data.channel) < CHANNELS;
    q_cmd.wbyte     = in_data.write_byte;
    q_cmd.max_count = mc;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ----- src/pprf_queue.sv -----
// Short command queue between the front and back ends.
// Depends on pprf_pkg.
`timescale 1ns / 1ps

module pprf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pprf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output pprf_pkg::cmd_t q_cmd
);
  import pprf_pkg::*;

  cmd_t            ent_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [QP_W-1:0] bump(input logic [QP_W-1:0] p);
    return (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : QP_W'(p + 1'b1);
  endfunction

  assign full    = cnt_r == QC_W'(QUEUE_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_cmd   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = QC_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = QC_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- src/pprf_back.sv -----
// Back end: channel state, byte store and the read sequencer, feeding the
// result register. Depends on pprf_pkg.
`timescale 1ns / 1ps

module pprf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  pprf_pkg::cmd_t        q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pprf_pkg::out_item_t   out_data,
  output pprf_pkg::bk_status_t  bk_stat
);
  import pprf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CHANNELS-1:0] active_r, active_nxt;
  logic [PTR_W-1:0]  wp_r [CHANNELS];
  logic [PTR_W-1:0]  wp_nxt [CHANNELS];
  logic [PTR_W-1:0]  rp_r [CHANNELS];
  logic [PTR_W-1:0]  rp_nxt [CHANNELS];
  logic [CNT_W-1:0]  cnt_r [CHANNELS];
  logic [CNT_W-1:0]  cnt_nxt [CHANNELS];
  logic [CH_W-1:0]   cur_ch_r, cur_ch_nxt;
  logic [MC_W-1:0]   rem_r, rem_nxt;

  logic [BYTE_W-1:0] mem_r [CHANNELS * FIFO_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [PTR_W-1:0]  rd_ptr;

  logic              out_valid_r;
  out_item_t         out_data_r, res;
  logic              produce, slot_free;

  logic [CH_W-1:0]   sel_ch, free_idx;
  logic              free_found;
  logic [CNT_W-1:0]  sel_cnt;
  logic [PTR_W-1:0]  sel_wp, sel_rp;
  logic [CMP_W-1:0]  cnt_x, mc_x;
  logic [MC_W-1:0]   take;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  function automatic logic [AW-1:0] mem_addr(input logic [CH_W-1:0] c,
                                             input logic [PTR_W-1:0] p);
    return AW'(AW'(c) * AW'(FIFO_DEPTH)) + AW'(p);
  endfunction

  assign slot_free = !out_valid_r || !out_stall;
  assign sel_ch    = (state_r == S_READ) ? cur_ch_r : q_cmd.ch;
  assign sel_cnt   = cnt_r[sel_ch];
  assign sel_wp    = wp_r[sel_ch];
  assign sel_rp    = rp_r[sel_ch];
  assign cnt_x     = CMP_W'(sel_cnt);
  assign mc_x      = CMP_W'(q_cmd.max_count);
  assign take      = (cnt_x < mc_x) ? MC_W'(cnt_x) : q_cmd.max_count;
  assign q_pop     = q_valid && (state_r == S_IDLE) && slot_free;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = CH_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    cnt_nxt    = cnt_r;
    cur_ch_nxt = cur_ch_r;
    rem_nxt    = rem_r;
    mem_we     = 1'b0;
    rd_ptr     = sel_rp;
    produce    = 1'b0;
    res        = '0;
    res.status = ST_OK;
    res.last   = 1'b1;

    if (q_pop) begin
      res.channel_out = q_cmd.chan;
      case (q_cmd.op)
        OP_CREATE: begin
          produce         = 1'b1;
          res.channel_out = '0;
          if (free_found) begin
            active_nxt[free_idx] = 1'b1;
            wp_nxt[free_idx]     = '0;
            rp_nxt[free_idx]     = '0;
            cnt_nxt[free_idx]    = '0;
            res.channel_out      = CHAN_W'(free_idx);
          end else begin
            res.status = ST_NO_FREE;
          end
        end
        OP_DESTROY: begin
          produce = 1'b1;
          if (q_cmd.ch_ok) begin
            active_nxt[q_cmd.ch] = 1'b0;
          end else begin
            res.status = ST_INACTIVE;
          end
        end
        OP_WRITE: begin
          produce = 1'b1;
          if (!(q_cmd.ch_ok && active_r[q_cmd.ch])) begin
            res.status = ST_INACTIVE;
          end else if (sel_cnt == CNT_W'(FIFO_DEPTH)) begin
            res.status     = ST_FULL;
            res.fill_level = FILL_W'(FIFO_DEPTH);
          end else begin
            mem_we            = 1'b1;
            wp_nxt[q_cmd.ch]  = bump(sel_wp);
            cnt_nxt[q_cmd.ch] = CNT_W'(sel_cnt + 1'b1);
            res.fill_level    = FILL_W'(CNT_W'(sel_cnt + 1'b1));
          end
        end
        OP_READ: begin
          if (!(q_cmd.ch_ok && active_r[q_cmd.ch])) begin
            produce    = 1'b1;
            res.status = ST_INACTIVE;
          end else if (sel_cnt == '0) begin
            produce    = 1'b1;
            res.status = ST_EMPTY;
          end else begin
            state_nxt  = S_READ;
            cur_ch_nxt = q_cmd.ch;
            rem_nxt    = take;
          end
        end
        default: begin
          produce = 1'b0;
        end
      endcase
    end else if (state_r == S_READ && slot_free) begin
      produce           = 1'b1;
      res.channel_out   = CHAN_W'(cur_ch_r);
      res.read_byte     = rd_data_r;
      res.fill_level    = FILL_W'(CNT_W'(sel_cnt - 1'b1));
      res.last          = rem_r == MC_W'(1);
      cnt_nxt[cur_ch_r] = CNT_W'(sel_cnt - 1'b1);
      rp_nxt[cur_ch_r]  = bump(sel_rp);
      rd_ptr            = bump(sel_rp);
      rem_nxt           = MC_W'(rem_r - 1'b1);
      if (rem_r == MC_W'(1)) begin
        state_nxt = S_IDLE;
      end
    end
  end

  assign wr_addr = mem_addr(q_cmd.ch, sel_wp);
  assign rd_addr = mem_addr(sel_ch, rd_ptr);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_addr] <= q_cmd.wbyte;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      cur_ch_r    <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wp_r[i]  <= '0;
        rp_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      cur_ch_r   <= cur_ch_nxt;
      rem_r      <= rem_nxt;
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      cnt_r      <= cnt_nxt;
      if (produce) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_data_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data          = out_data_r;
  assign bk_stat.reading   = state_r == S_READ;
  assign bk_stat.remaining = rem_r;

endmodule
